/* rtl/plsq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// plsq_pkg
// Shared types and constants for the positional list / stack / queue block.
// ----------------------------------------------------------------------------
package plsq_pkg;

  localparam int unsigned VALUE_W = 32;  // stored value width
  localparam int unsigned POS_W   = 5;   // request position field width
  localparam int unsigned COUNT_W = 5;   // reported entry count width

  typedef enum logic [1:0] {
    REQ_INS_POS  = 2'd0,
    REQ_REM_POS  = 2'd1,
    REQ_INS_TAIL = 2'd2,
    REQ_REM_TAIL = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_RM_RD0,
    S_RM_GET,
    S_RM_RD,
    S_RM_WR
  } state_t;

endpackage : plsq_pkg
`default_nettype wire

/* rtl/positional_list_stack_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_stack_queue
// Bounded ordered list of signed 32-bit values with insert and remove at any
// position or at the tail; entries are moved one at a time through a memory.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Every transaction
// gives exactly one result, shown for a single cycle with out_valid high; the
// receiver cannot stall it, so sample it on that cycle. A rejected request
// (empty list, bad position, full list) leaves busy low, and the result
// follows on the next cycle. A good insert at position p keeps busy high while
// the entries from p to the tail move up one place; a good remove at p fetches
// the target, then moves each later entry down one place. The duration is set
// by the registered memory read and the single index unit (increment/decrement
// and compare) that walks the shift: each moved entry needs a read state and a
// write state. Tail insert is the fastest request, a head remove on a full list
// the slowest. The result is strobed in the first cycle that busy is low again,
// and a new transaction may be taken in that same cycle. Reset clears the
// state, the entry count and the result strobe; no memory clearing pass.
// ----------------------------------------------------------------------------
module positional_list_stack_queue
  import plsq_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // request channel
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [1:0]                in_req_type,
  input  wire logic signed [VALUE_W-1:0] in_value,
  input  wire logic [POS_W-1:0]          in_position,
  // result channel
  output logic                           out_valid,
  output logic signed [VALUE_W-1:0]      out_removed_value,
  output logic [1:0]                     out_status,
  output logic [COUNT_W-1:0]             out_entry_count,
  output logic                           out_is_empty
);

  // Widths that follow from the capacity.
  localparam int unsigned IDX_W = $clog2(CAPACITY);      // memory address
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);  // 0..CAPACITY
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // List storage: one read and one write port, registered read data.
  logic [VALUE_W-1:0] mem [CAPACITY];
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [VALUE_W-1:0] rd_data_r;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [VALUE_W-1:0] wr_data;

  // Sequencer state.
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;     // entries stored
  logic [IDX_W-1:0]   idx_r, idx_nxt;     // walking index of the shift
  logic [IDX_W-1:0]   pos_r, pos_nxt;     // target position
  logic [VALUE_W-1:0] val_r, val_nxt;     // insert value, or removed value

  // Result registers.
  logic               out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0] out_val_r, out_val_nxt;
  status_t            out_st_r, out_st_nxt;
  logic [COUNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic               out_emp_r, out_emp_nxt;

  logic               accept;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // --------------------------------------------------------------------------
  // Memory
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    pos_r     <= pos_nxt;
    val_r     <= val_nxt;
    out_val_r <= out_val_nxt;
    out_st_r  <= out_st_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_emp_r <= out_emp_nxt;
  end

  // --------------------------------------------------------------------------
  // Sequencer: request check on accept, then one entry moved per read/write.
  // --------------------------------------------------------------------------
  always_comb begin
    logic [CMP_W-1:0] pos_x;
    logic [CMP_W-1:0] cnt_x;
    logic [CMP_W-1:0] at_x;
    logic             is_ins;
    status_t          st;

    pos_x  = CMP_W'(in_position);
    cnt_x  = CMP_W'(cnt_r);
    at_x   = pos_x;
    is_ins = 1'b1;
    st     = ST_OK;

    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    rd_en         = 1'b0;
    rd_addr       = idx_r;
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_data       = rd_data_r;
    out_valid_nxt = 1'b0;
    out_val_nxt   = out_val_r;
    out_st_nxt    = out_st_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (req_t'(in_req_type))
            REQ_INS_POS: begin
              is_ins = 1'b1;
              at_x   = pos_x;
            end
            REQ_REM_POS: begin
              is_ins = 1'b0;
              at_x   = pos_x;
            end
            REQ_INS_TAIL: begin
              is_ins = 1'b1;
              at_x   = cnt_x;
            end
            REQ_REM_TAIL: begin
              is_ins = 1'b0;
              at_x   = cnt_x - CMP_W'(1);
            end
            default: begin
              is_ins = 1'b1;
              at_x   = pos_x;
            end
          endcase

          // position is checked before fullness; emptiness before position
          if (is_ins) begin
            if (at_x > cnt_x) begin
              st = ST_BADPOS;
            end else if (cnt_r >= CNT_W'(CAPACITY)) begin
              st = ST_FULL;
            end
          end else begin
            if (cnt_r == '0) begin
              st = ST_EMPTY;
            end else if (at_x >= cnt_x) begin
              st = ST_BADPOS;
            end
          end

          if (st == ST_OK) begin
            pos_nxt   = at_x[IDX_W-1:0];
            val_nxt   = in_value;
            if (is_ins) begin
              idx_nxt   = cnt_r[IDX_W-1:0];
              state_nxt = S_INS_RD;
            end else begin
              idx_nxt   = at_x[IDX_W-1:0];
              state_nxt = S_RM_RD0;
            end
          end else begin
            out_valid_nxt = 1'b1;
            out_val_nxt   = '0;
            out_st_nxt    = st;
          end
        end
      end

      // insert: walk from the tail down to the target, moving each entry up
      S_INS_RD: begin
        if (idx_r == pos_r) begin
          wr_en         = 1'b1;
          wr_addr       = pos_r;
          wr_data       = val_r;
          cnt_nxt       = cnt_r + CNT_W'(1);
          out_valid_nxt = 1'b1;
          out_val_nxt   = '0;
          out_st_nxt    = ST_OK;
          state_nxt     = S_IDLE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = idx_r - IDX_W'(1);
          state_nxt = S_INS_WR;
        end
      end

      S_INS_WR: begin
        wr_en     = 1'b1;
        wr_addr   = idx_r;
        wr_data   = rd_data_r;
        idx_nxt   = idx_r - IDX_W'(1);
        state_nxt = S_INS_RD;
      end

      // remove: fetch the target, then pull later entries down one place
      S_RM_RD0: begin
        rd_en     = 1'b1;
        rd_addr   = idx_r;
        state_nxt = S_RM_GET;
      end

      S_RM_GET: begin
        val_nxt   = rd_data_r;
        state_nxt = S_RM_RD;
      end

      S_RM_RD: begin
        if ((CNT_W'(idx_r) + CNT_W'(1)) >= cnt_r) begin
          cnt_nxt       = cnt_r - CNT_W'(1);
          out_valid_nxt = 1'b1;
          out_val_nxt   = val_r;
          out_st_nxt    = ST_OK;
          state_nxt     = S_IDLE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = idx_r + IDX_W'(1);
          state_nxt = S_RM_WR;
        end
      end

      S_RM_WR: begin
        wr_en     = 1'b1;
        wr_addr   = idx_r;
        wr_data   = rd_data_r;
        idx_nxt   = idx_r + IDX_W'(1);
        state_nxt = S_RM_RD;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // count reported is the count after this request
    out_cnt_nxt = out_valid_nxt ? COUNT_W'(cnt_nxt) : out_cnt_r;
    out_emp_nxt = out_valid_nxt ? (cnt_nxt == '0) : out_emp_r;
  end

  // --------------------------------------------------------------------------
  // Outputs
  // --------------------------------------------------------------------------
  assign out_valid         = out_valid_r;
  assign out_removed_value = out_val_r;
  assign out_status        = out_st_r;
  assign out_entry_count   = out_cnt_r;
  assign out_is_empty      = out_emp_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_valid)
    else $error("result strobe while a transaction is in progress");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_valid || busy))
    else $error("accepted transaction neither finished nor in progress");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_st_r != ST_OK)) |-> (out_removed_value == '0))
    else $error("failed request returned a nonzero value");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_st_r == ST_EMPTY)) |-> out_is_empty)
    else $error("empty status with entries stored");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |-> $past(state_r == S_INS_RD || state_r == S_RM_RD))
    else $error("entry count changed outside a finishing step");

endmodule : positional_list_stack_queue
`default_nettype wire
